[design/rgb_led_strip_frame_driver_top_macros.svh]
// ----------------------------------------------------------------------------
// RGB LED strip frame driver: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_STRIP_FRAME_DRIVER_TOP_MACROS_SVH
`define RGB_LED_STRIP_FRAME_DRIVER_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define RLSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rlsd: property failed");

// check that a signal holds in the cycle after a condition
`define RLSD_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("rlsd: value did not hold");

`endif

[design/rlsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip frame driver package
// Field widths, operation and register codes, and shared types.
// ----------------------------------------------------------------------------
package rlsd_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 8;
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_REG_W  = 9;
    localparam int TICK_REG_W = 16;
    localparam int BIT_W      = 5;
    localparam logic [BIT_W-1:0] BIT_LAST = 5'd23;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_REFRESH = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_COUNT  = 3'd0,
        CFG_ONE_HIGH   = 3'd1,
        CFG_ONE_LOW    = 3'd2,
        CFG_ZERO_HIGH  = 3'd3,
        CFG_ZERO_LOW   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [TICK_REG_W-1:0] one_high;
        logic [TICK_REG_W-1:0] one_low;
        logic [TICK_REG_W-1:0] zero_high;
        logic [TICK_REG_W-1:0] zero_low;
    } t_tick_cfg;

    typedef struct packed {
        logic start;
        logic tick;
    } t_ser_cmd;

    typedef struct packed {
        logic line;
        logic word_last;
    } t_ser_stat;

    function automatic logic [PIX_W-1:0] grb_of(input logic [PIX_W-1:0] color);
        return {color[15:8], color[23:16], color[7:0]};
    endfunction

endpackage

[design/rlsd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip frame driver channel interfaces
// Item input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rlsd_in_if;
    logic                          valid;
    logic                          ready;
    logic [rlsd_pkg::OP_W-1:0]     op;
    logic [rlsd_pkg::IDX_W-1:0]    pixel_index;
    logic [rlsd_pkg::PIX_W-1:0]    pixel_color;

    modport source (output valid, op, pixel_index, pixel_color, input ready);
    modport sink   (input valid, op, pixel_index, pixel_color, output ready);
endinterface

interface rlsd_out_if;
    logic valid;
    logic ready;
    logic data_line;
    logic busy_res;
    logic rejected;
    logic frame_done;

    modport source (output valid, data_line, busy_res, rejected, frame_done, input ready);
    modport sink   (input valid, data_line, busy_res, rejected, frame_done, output ready);
endinterface

interface rlsd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rlsd_pkg::CFG_IDX_W-1:0]   index;
    logic [rlsd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/rlsd_pixel_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip pixel memory
// One write port, one registered read port, zero sweep after reset.
// ----------------------------------------------------------------------------
module rlsd_pixel_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [rlsd_pkg::PIX_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [rlsd_pkg::PIX_W-1:0] o_rdata,
    output logic                       o_clr_done
);

    logic [rlsd_pkg::PIX_W-1:0] mem [DEPTH];
    logic [rlsd_pkg::PIX_W-1:0] r_rdata;
    logic [AW-1:0]              r_clr_addr;
    logic                       r_clr_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clr_done = r_clr_done;

endmodule

[design/rlsd_bit_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip bit serializer
// Shifts one GRB word out MSB first, timing each high and low phase.
// ----------------------------------------------------------------------------
module rlsd_bit_serializer #(
    parameter int TW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rlsd_pkg::t_ser_cmd         i_cmd,
    input  logic [rlsd_pkg::PIX_W-1:0] i_word,
    input  rlsd_pkg::t_tick_cfg        i_tick_cfg,
    output rlsd_pkg::t_ser_stat        o_stat
);

    logic [rlsd_pkg::PIX_W-1:0] r_shift;
    logic [rlsd_pkg::BIT_W-1:0] r_bit;
    logic                       r_high;
    logic [TW-1:0]              r_left;

    function automatic logic [TW-1:0] tick_len(input logic [rlsd_pkg::TICK_REG_W-1:0] v);
        logic [TW-1:0] t;
        t = TW'(v);
        return (t == '0) ? TW'(1) : t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_bit   <= '0;
            r_high  <= 1'b0;
            r_left  <= '0;
        end else if (i_cmd.start) begin
            r_shift <= i_word;
            r_bit   <= '0;
            r_high  <= 1'b1;
            r_left  <= tick_len(i_word[23] ? i_tick_cfg.one_high : i_tick_cfg.zero_high);
        end else if (i_cmd.tick) begin
            if (r_left > TW'(1)) begin
                r_left <= r_left - TW'(1);
            end else if (r_high) begin
                r_high <= 1'b0;
                r_left <= tick_len(r_shift[23] ? i_tick_cfg.one_low : i_tick_cfg.zero_low);
            end else if (r_bit == rlsd_pkg::BIT_LAST) begin
                r_bit   <= '0;
                r_shift <= '0;
                r_left  <= '0;
            end else begin
                r_bit   <= r_bit + rlsd_pkg::BIT_W'(1);
                r_shift <= {r_shift[22:0], 1'b0};
                r_high  <= 1'b1;
                r_left  <= tick_len(r_shift[22] ? i_tick_cfg.one_high : i_tick_cfg.zero_high);
            end
        end
    end

    assign o_stat.line      = r_high;
    assign o_stat.word_last = (r_left <= TW'(1)) && !r_high && (r_bit == rlsd_pkg::BIT_LAST);

endmodule

[design/rgb_led_strip_frame_driver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip frame driver
// Pixel store and serial waveform generator for a strip of RGB LEDs.
// ----------------------------------------------------------------------------
// After reset the pixel memory is swept to zero, during which no item is taken
// (configuration writes are). Each item then gives one result word. Ticks,
// writes, rejected items and unused codes give it directly from S_IDLE. A refresh
// that starts a frame, and the tick that closes the last bit of an LED when
// another LED follows, pass through S_LOAD first: the next color comes out of
// the single registered read port of the pixel memory before it is loaded
// into the bit shift register. An input word is taken only when the result
// register is empty or being drained in the same cycle.
module rgb_led_strip_frame_driver_top #(
    parameter int MAX_LEDS           = 256,
    parameter int TICK_COUNTER_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rlsd_in_if.sink        i_in,
    rlsd_out_if.source     o_out,
    rlsd_cfg_if.sink       i_cfg
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = $clog2(MAX_LEDS + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD
    } t_state;

    t_state                             r_state, n_state;
    logic                               r_sending, n_sending;
    logic [AW-1:0]                      r_led_pos, n_led_pos;
    logic                               r_pend_line, n_pend_line;
    logic                               r_out_valid, n_out_valid;
    logic                               r_line, n_line;
    logic                               r_busy, n_busy;
    logic                               r_rej, n_rej;
    logic                               r_done, n_done;
    logic [rlsd_pkg::CNT_REG_W-1:0]     r_led_count;
    rlsd_pkg::t_tick_cfg                r_tick_cfg;

    logic                               in_acc;
    logic [CW-1:0]                      eff_cnt;
    logic                               idx_bad;
    logic                               last_led;
    rlsd_pkg::t_op                      op;
    rlsd_pkg::t_ser_cmd                 ser_cmd;
    rlsd_pkg::t_ser_stat                ser_stat;
    logic                               mem_we;
    logic [AW-1:0]                      mem_raddr;
    logic [rlsd_pkg::PIX_W-1:0]         mem_rdata;
    logic                               clr_done;

    assign op      = rlsd_pkg::t_op'(i_in.op);
    assign eff_cnt = (32'(r_led_count) > MAX_LEDS) ? CW'(MAX_LEDS) : CW'(r_led_count);
    assign idx_bad = 32'(i_in.pixel_index) >= 32'(eff_cnt);
    assign last_led = (32'(r_led_pos) + 32'd1) >= 32'(eff_cnt);

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign mem_raddr = (op == rlsd_pkg::OP_REFRESH) ? '0 : (r_led_pos + AW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count          <= '0;
            r_tick_cfg.one_high  <= 16'd40;
            r_tick_cfg.one_low   <= 16'd22;
            r_tick_cfg.zero_high <= 16'd20;
            r_tick_cfg.zero_low  <= 16'd42;
        end else if (i_cfg.valid) begin
            unique case (rlsd_pkg::t_cfg_idx'(i_cfg.index))
                rlsd_pkg::CFG_LED_COUNT: r_led_count <= i_cfg.data[rlsd_pkg::CNT_REG_W-1:0];
                rlsd_pkg::CFG_ONE_HIGH:  r_tick_cfg.one_high  <= i_cfg.data;
                rlsd_pkg::CFG_ONE_LOW:   r_tick_cfg.one_low   <= i_cfg.data;
                rlsd_pkg::CFG_ZERO_HIGH: r_tick_cfg.zero_high <= i_cfg.data;
                rlsd_pkg::CFG_ZERO_LOW:  r_tick_cfg.zero_low  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sending   = r_sending;
        n_led_pos   = r_led_pos;
        n_pend_line = r_pend_line;
        n_out_valid = r_out_valid && !o_out.ready;
        n_line      = r_line;
        n_busy      = r_busy;
        n_rej       = r_rej;
        n_done      = r_done;
        ser_cmd     = '0;
        mem_we      = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                if (clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_line      = r_sending && ser_stat.line;
                    n_busy      = r_sending;
                    n_rej       = 1'b0;
                    n_done      = 1'b0;
                    unique case (op)
                        rlsd_pkg::OP_TICK: begin
                            if (r_sending) begin
                                ser_cmd.tick = 1'b1;
                                if (ser_stat.word_last) begin
                                    if (last_led) begin
                                        n_sending = 1'b0;
                                        n_led_pos = '0;
                                        n_busy    = 1'b0;
                                        n_done    = 1'b1;
                                    end else begin
                                        n_led_pos   = r_led_pos + AW'(1);
                                        n_pend_line = 1'b0;
                                        n_out_valid = 1'b0;
                                        n_state     = S_LOAD;
                                    end
                                end
                            end
                        end
                        rlsd_pkg::OP_WRITE: begin
                            if (r_sending || idx_bad) begin
                                n_rej = 1'b1;
                            end else begin
                                mem_we = 1'b1;
                            end
                        end
                        rlsd_pkg::OP_REFRESH: begin
                            if (r_sending) begin
                                n_rej = 1'b1;
                            end else if (eff_cnt == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_sending   = 1'b1;
                                n_led_pos   = '0;
                                n_pend_line = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = S_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                ser_cmd.start = 1'b1;
                n_out_valid   = 1'b1;
                n_line        = r_pend_line;
                n_busy        = 1'b1;
                n_rej         = 1'b0;
                n_done        = 1'b0;
                n_state       = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sending   <= 1'b0;
            r_led_pos   <= '0;
            r_pend_line <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sending   <= n_sending;
            r_led_pos   <= n_led_pos;
            r_pend_line <= n_pend_line;
            r_out_valid <= n_out_valid;
        end
        r_line <= n_line;
        r_busy <= n_busy;
        r_rej  <= n_rej;
        r_done <= n_done;
    end

    rlsd_pixel_mem #(
        .DEPTH (MAX_LEDS),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (mem_we),
        .i_waddr    (AW'(i_in.pixel_index)),
        .i_wdata    (rlsd_pkg::grb_of(i_in.pixel_color)),
        .i_raddr    (mem_raddr),
        .o_rdata    (mem_rdata),
        .o_clr_done (clr_done)
    );

    rlsd_bit_serializer #(
        .TW (TICK_COUNTER_WIDTH)
    ) u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ser_cmd),
        .i_word     (mem_rdata),
        .i_tick_cfg (r_tick_cfg),
        .o_stat     (ser_stat)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.data_line  = r_line;
    assign o_out.busy_res   = r_busy;
    assign o_out.rejected   = r_rej;
    assign o_out.frame_done = r_done;

endmodule

[design/rlsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip frame driver port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "rgb_led_strip_frame_driver_top_macros.svh"

module rlsd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_data_line,
    input logic i_busy_res,
    input logic i_rejected,
    input logic i_frame_done
);

    logic out_stall;
    logic in_acc;
    logic [3:0] out_word;

    assign out_stall = i_out_valid && !i_out_ready;
    assign in_acc    = i_in_valid && i_in_ready;
    assign out_word  = {i_data_line, i_busy_res, i_rejected, i_frame_done};

    `RLSD_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, out_stall, out_word)
    `RLSD_ASSERT(a_no_accept_on_stall, i_clk, i_rst_n, in_acc |-> !out_stall)
    `RLSD_ASSERT(a_done_not_busy, i_clk, i_rst_n, (i_out_valid && i_frame_done) |-> !i_busy_res)
    `RLSD_ASSERT(a_done_not_rej, i_clk, i_rst_n, (i_out_valid && i_rejected) |-> !i_frame_done)
    `RLSD_ASSERT(a_line_needs_busy, i_clk, i_rst_n, (i_out_valid && !i_busy_res && !i_frame_done) |-> !i_data_line)

endmodule

bind rgb_led_strip_frame_driver_top rlsd_checker u_rlsd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_line  (o_out.data_line),
    .i_busy_res   (o_out.busy_res),
    .i_rejected   (o_out.rejected),
    .i_frame_done (o_out.frame_done)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip frame driver testbench
// Sends pixel writes, refreshes, unused codes and timing ticks through the
// item channel, programs the LED count and the four phase lengths through the
// register channel, and keeps its own copy of the pixel memory and serializer
// state to work out each result word. Every word is checked field by field:
// line level, busy, reject and frame-done. The item and result channels idle at
// random, and one stretch holds the result side off so that the block backs up.
// ----------------------------------------------------------------------------
module tb;

    localparam int STRIP_LEDS    = 256;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 150;

    localparam int IDX_W      = rlsd_pkg::IDX_W;
    localparam int PIX_W      = rlsd_pkg::PIX_W;
    localparam int CNT_REG_W  = rlsd_pkg::CNT_REG_W;
    localparam int TICK_REG_W = rlsd_pkg::TICK_REG_W;
    localparam int CFG_DATA_W = rlsd_pkg::CFG_DATA_W;

    typedef struct packed {
        logic line;
        logic busy;
        logic rej;
        logic done;
    } t_strip_word;

    logic i_clk;
    logic i_rst_n;

    rlsd_in_if  in_if ();
    rlsd_out_if out_if ();
    rlsd_cfg_if cfg_if ();

    rgb_led_strip_frame_driver_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    logic [CNT_REG_W-1:0]  cfg_count     = '0;
    logic [TICK_REG_W-1:0] cfg_one_high  = 16'd40;
    logic [TICK_REG_W-1:0] cfg_one_low   = 16'd22;
    logic [TICK_REG_W-1:0] cfg_zero_high = 16'd20;
    logic [TICK_REG_W-1:0] cfg_zero_low  = 16'd42;

    logic [PIX_W-1:0] led_colors [STRIP_LEDS];
    bit               strip_busy = 1'b0;
    bit               high_phase = 1'b0;
    int unsigned      led_pos    = 0;
    int unsigned      bit_pos    = 0;
    int unsigned      ticks_left = 0;
    logic [PIX_W-1:0] grb_shift  = '0;

    t_strip_word pending_words [$];

    int unsigned mismatches    = 0;
    int unsigned words_checked = 0;
    int unsigned items_sent    = 0;
    int unsigned live_items    = 0;
    int unsigned frames_sent   = 0;
    bit          idle_en       = 1'b1;
    bit          sink_hold     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [PIX_W-1:0] color_to_wire(input logic [PIX_W-1:0] c);
        return {c[15:8], c[23:16], c[7:0]};
    endfunction

    function automatic void load_phase(input bit high);
        logic [TICK_REG_W-1:0] len;
        if (grb_shift[PIX_W-1]) begin
            len = high ? cfg_one_high : cfg_one_low;
        end else begin
            len = high ? cfg_zero_high : cfg_zero_low;
        end
        high_phase = high;
        ticks_left = (len == '0) ? 1 : len;
    endfunction

    function automatic void advance_strip(input rlsd_pkg::t_op op,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [PIX_W-1:0] color);
        t_strip_word w;
        int unsigned cnt;
        w   = '0;
        cnt = (cfg_count > STRIP_LEDS) ? STRIP_LEDS : cfg_count;
        case (op)
            rlsd_pkg::OP_TICK: begin
                if (strip_busy) begin
                    live_items++;
                    w.line = high_phase;
                    if (ticks_left > 1) begin
                        ticks_left--;
                    end else if (high_phase) begin
                        load_phase(1'b0);
                    end else begin
                        bit_pos++;
                        if (bit_pos >= 24) begin
                            bit_pos = 0;
                            if (led_pos + 1 >= cnt) begin
                                strip_busy = 1'b0;
                                high_phase = 1'b0;
                                ticks_left = 0;
                                led_pos    = 0;
                                grb_shift  = '0;
                                w.done     = 1'b1;
                                frames_sent++;
                            end else begin
                                led_pos++;
                                grb_shift = color_to_wire(led_colors[led_pos]);
                                load_phase(1'b1);
                            end
                        end else begin
                            grb_shift = grb_shift << 1;
                            load_phase(1'b1);
                        end
                    end
                end
            end
            rlsd_pkg::OP_WRITE: begin
                if (strip_busy || idx >= cnt) begin
                    w.rej = 1'b1;
                end else begin
                    led_colors[idx] = color;
                    live_items++;
                end
            end
            rlsd_pkg::OP_REFRESH: begin
                if (strip_busy) begin
                    w.rej = 1'b1;
                end else if (cnt == 0) begin
                    w.done = 1'b1;
                    live_items++;
                end else begin
                    strip_busy = 1'b1;
                    led_pos    = 0;
                    bit_pos    = 0;
                    grb_shift  = color_to_wire(led_colors[0]);
                    load_phase(1'b1);
                    live_items++;
                end
            end
            default: begin
            end
        endcase
        if (op != rlsd_pkg::OP_TICK) begin
            w.line = strip_busy && high_phase;
        end
        w.busy = strip_busy;
        pending_words.push_back(w);
    endfunction

    task automatic report_mismatch(input string field, input logic exp_v, input logic got_v);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] %s mismatch on word %0d: expected %b got %b",
                     $time, field, words_checked, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : check_words
        t_strip_word exp_w;
        t_strip_word got_w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_w = {out_if.data_line, out_if.busy_res, out_if.rejected, out_if.frame_done};
            if (pending_words.size() == 0) begin
                report_mismatch("word with none due", 1'b0, 1'b1);
            end else begin
                exp_w = pending_words.pop_front();
                if (got_w.line !== exp_w.line) report_mismatch("data_line", exp_w.line, got_w.line);
                if (got_w.busy !== exp_w.busy) report_mismatch("busy_res", exp_w.busy, got_w.busy);
                if (got_w.rej !== exp_w.rej) report_mismatch("rejected", exp_w.rej, got_w.rej);
                if (got_w.done !== exp_w.done) begin
                    report_mismatch("frame_done", exp_w.done, got_w.done);
                end
            end
            words_checked++;
        end
    end

    initial begin : drain
        int gap_left;
        gap_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                gap_left = (idle_en && $urandom_range(0, 1) == 1) ? $urandom_range(1, 16) : 0;
            end
            if (sink_hold) begin
                out_if.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input rlsd_pkg::t_op op, input logic [IDX_W-1:0] idx,
                             input logic [PIX_W-1:0] color);
        int gap;
        gap = (idle_en && $urandom_range(0, 1) == 1) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.pixel_index <= idx;
        in_if.pixel_color <= color;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        advance_strip(op, idx, color);
    endtask

    task automatic send_tick();
        send_word(rlsd_pkg::OP_TICK, IDX_W'($urandom), PIX_W'($urandom));
    endtask

    task automatic tick_until_idle();
        while (strip_busy) send_tick();
    endtask

    // drop valid, wait for every due word, then let the block go quiet
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input rlsd_pkg::t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            rlsd_pkg::CFG_LED_COUNT: cfg_count     = data[CNT_REG_W-1:0];
            rlsd_pkg::CFG_ONE_HIGH:  cfg_one_high  = data;
            rlsd_pkg::CFG_ONE_LOW:   cfg_one_low   = data;
            rlsd_pkg::CFG_ZERO_HIGH: cfg_zero_high = data;
            rlsd_pkg::CFG_ZERO_LOW:  cfg_zero_low  = data;
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_phases(input logic [TICK_REG_W-1:0] one_high,
                                input logic [TICK_REG_W-1:0] one_low,
                                input logic [TICK_REG_W-1:0] zero_high,
                                input logic [TICK_REG_W-1:0] zero_low);
        write_reg(rlsd_pkg::CFG_ONE_HIGH, one_high);
        write_reg(rlsd_pkg::CFG_ONE_LOW, one_low);
        write_reg(rlsd_pkg::CFG_ZERO_HIGH, zero_high);
        write_reg(rlsd_pkg::CFG_ZERO_LOW, zero_low);
    endtask

    function automatic logic [TICK_REG_W-1:0] pick_ticks();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 7) return TICK_REG_W'($urandom_range(1, 2));
        return TICK_REG_W'($urandom_range(3, 5));
    endfunction

    task automatic test_idle_items();
        send_word(rlsd_pkg::OP_TICK, 8'h00, 24'h000000);
        send_word(rlsd_pkg::OP_WRITE, 8'h00, 24'hFFFFFF);
        send_word(rlsd_pkg::OP_WRITE, 8'hFF, 24'h000000);
        send_word(rlsd_pkg::OP_REFRESH, 8'hFF, 24'hFFFFFF);
        send_word(rlsd_pkg::OP_NONE, 8'hFF, 24'hFFFFFF);
        send_word(rlsd_pkg::OP_NONE, 8'h00, 24'h000000);
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd300);
        send_word(rlsd_pkg::OP_WRITE, 8'hFF, 24'hA5A5A5);
        send_word(rlsd_pkg::OP_WRITE, 8'h00, 24'h5A5A5A);
        send_word(rlsd_pkg::OP_TICK, 8'hFF, 24'hFFFFFF);
    endtask

    task automatic test_reset_timing();
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd1);
        send_word(rlsd_pkg::OP_WRITE, 8'd1, 24'h123456);
        send_word(rlsd_pkg::OP_WRITE, 8'd0, 24'h008000);
        send_word(rlsd_pkg::OP_REFRESH, 8'd0, 24'h000000);
        repeat (64) send_tick();
        send_word(rlsd_pkg::OP_REFRESH, 8'd0, 24'h000000);
        send_word(rlsd_pkg::OP_WRITE, 8'd0, 24'hFFFFFF);
        settle();
        write_phases('0, '0, '0, '0);
        tick_until_idle();
        send_tick();
    endtask

    task automatic test_count_shrink();
        int i;
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd4);
        write_phases(16'd2, 16'd1, 16'd1, 16'd2);
        for (i = 0; i < 4; i++) send_word(rlsd_pkg::OP_WRITE, i[IDX_W-1:0], PIX_W'($urandom));
        send_word(rlsd_pkg::OP_REFRESH, IDX_W'($urandom), PIX_W'($urandom));
        repeat (80) send_tick();
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd1);
        tick_until_idle();
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd3);
        send_word(rlsd_pkg::OP_REFRESH, IDX_W'($urandom), PIX_W'($urandom));
        repeat (10) send_tick();
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd0);
        tick_until_idle();
    endtask

    task automatic test_backpressure();
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd1);
        write_phases(16'd1, 16'd2, 16'd2, 16'd1);
        idle_en = 1'b0;
        send_word(rlsd_pkg::OP_REFRESH, IDX_W'($urandom), PIX_W'($urandom));
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        repeat (40) send_tick();
        tick_until_idle();
        idle_en = 1'b1;
    endtask

    task automatic test_long_phase();
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd1);
        write_phases(16'd1, 16'd1, 16'd64, 16'd1);
        send_word(rlsd_pkg::OP_WRITE, 8'd0, 24'h000000);
        idle_en = 1'b0;
        send_word(rlsd_pkg::OP_REFRESH, IDX_W'($urandom), PIX_W'($urandom));
        repeat (65) send_tick();
        settle();
        write_reg(rlsd_pkg::CFG_ZERO_HIGH, 16'd1);
        tick_until_idle();
        idle_en = 1'b1;
    endtask

    task automatic test_full_strip();
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'd256);
        write_phases(16'd1, 16'd1, 16'd1, 16'd1);
        send_word(rlsd_pkg::OP_WRITE, 8'hFF, PIX_W'($urandom));
        send_word(rlsd_pkg::OP_WRITE, 8'h00, PIX_W'($urandom));
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'hFFFF);
        send_word(rlsd_pkg::OP_WRITE, 8'hFF, PIX_W'($urandom));
        send_word(rlsd_pkg::OP_WRITE, 8'h80, PIX_W'($urandom));
        settle();
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'hFE00);
        send_word(rlsd_pkg::OP_WRITE, 8'h00, PIX_W'($urandom));
        send_word(rlsd_pkg::OP_REFRESH, IDX_W'($urandom), PIX_W'($urandom));
    endtask

    task automatic idle_item(input int unsigned n);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4 && n > 0) begin
            send_word(rlsd_pkg::OP_WRITE, IDX_W'($urandom_range(0, n - 1)), PIX_W'($urandom));
        end else if (r < 6) begin
            send_word(rlsd_pkg::OP_WRITE, IDX_W'($urandom), PIX_W'($urandom));
        end else if (r < 8) begin
            send_tick();
        end else begin
            send_word(rlsd_pkg::OP_NONE, IDX_W'($urandom), PIX_W'($urandom));
        end
    endtask

    task automatic run_random_frame();
        int unsigned n;
        int unsigned pick;
        int unsigned r;
        int unsigned mid_at;
        int unsigned ticks_in;
        logic [6:0]  count_hi;
        bit          do_mid;
        settle();
        idle_en = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            n = 0;
        end else if (pick == 1) begin
            n = $urandom_range(3, 4);
        end else begin
            n = $urandom_range(1, 2);
        end
        count_hi = ($urandom_range(0, 3) == 0) ? 7'($urandom) : '0;
        write_reg(rlsd_pkg::CFG_LED_COUNT, {count_hi, n[CNT_REG_W-1:0]});
        write_phases(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
        repeat ($urandom_range(0, 5)) idle_item(n);
        send_word(rlsd_pkg::OP_REFRESH, IDX_W'($urandom), PIX_W'($urandom));
        do_mid   = ($urandom_range(0, 2) == 0);
        mid_at   = $urandom_range(1, 80);
        ticks_in = 0;
        while (strip_busy) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                send_word(rlsd_pkg::OP_WRITE, IDX_W'($urandom), PIX_W'($urandom));
            end else if (r == 1) begin
                send_word(rlsd_pkg::OP_REFRESH, IDX_W'($urandom), PIX_W'($urandom));
            end else if (r == 2) begin
                send_word(rlsd_pkg::OP_NONE, IDX_W'($urandom), PIX_W'($urandom));
            end else begin
                send_tick();
                ticks_in++;
            end
            if (do_mid && ticks_in == mid_at) begin
                do_mid = 1'b0;
                settle();
                r = $urandom_range(0, 4);
                if (r == rlsd_pkg::CFG_LED_COUNT) begin
                    write_reg(rlsd_pkg::CFG_LED_COUNT, CFG_DATA_W'($urandom_range(0, n)));
                end else begin
                    write_reg(rlsd_pkg::t_cfg_idx'(r), pick_ticks());
                end
            end
        end
        repeat ($urandom_range(0, 3)) idle_item(n);
    endtask

    task automatic test_random_frames();
        int unsigned first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) run_random_frame();
        idle_en = 1'b1;
    endtask

    initial begin : main
        int i;
        for (i = 0; i < STRIP_LEDS; i++) led_colors[i] = '0;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.op          <= rlsd_pkg::OP_TICK;
        in_if.pixel_index <= '0;
        in_if.pixel_color <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= rlsd_pkg::CFG_LED_COUNT;
        cfg_if.data       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_items();
        test_reset_timing();
        test_count_shrink();
        test_backpressure();
        test_long_phase();
        test_full_strip();
        test_random_frames();

        settle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d items (%0d that changed state), %0d result words, %0d frames",
                 items_sent, live_items, words_checked, frames_sent);
        $display("led counts 0 to 511, phase lengths 0 to 64 ticks, result hold-off %0d cycles",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/rlsd_pkg.sv
design/rlsd_if.sv
design/rlsd_pixel_mem.sv
design/rlsd_bit_serializer.sv
design/rgb_led_strip_frame_driver_top.sv
design/rlsd_checker.sv
dv/tb.sv
